// File: hw/rtl/nlp_pkg.sv
// Shared types, constants and digit arithmetic for the numeric literal parser.
package nlp_pkg;

  localparam int ACC_W   = 64;
  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 8;
  localparam int DV_W    = 9;

  localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_O    = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_B    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_H    = 8'h68;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  typedef logic signed [DV_W-1:0] dig_t;
  typedef logic [ACC_W-1:0]       acc_t;

  typedef enum logic [1:0] {
    RDX_DEC = 2'd0,
    RDX_HEX = 2'd1,
    RDX_BIN = 2'd2,
    RDX_OCT = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_HEX  = 2'd1,
    PFX_OCT  = 2'd2,
    PFX_BIN  = 2'd3
  } pfx_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      ok;
  } out_item_t;

  typedef struct packed {
    dig_t dv;
    logic is_x;
    logic is_o;
    logic is_b;
    logic is_h;
    logic is_zero;
  } dchar_t;

  function automatic acc_t acc_push(input acc_t acc, input radix_t rdx, input dig_t dv);
    acc_t m;
    case (rdx)
      RDX_DEC: m = (acc << 3) + (acc << 1);
      RDX_HEX: m = acc << 4;
      RDX_BIN: m = acc << 1;
      RDX_OCT: m = acc << 3;
      default: m = acc;
    endcase
    return m + ACC_W'(dv);
  endfunction

  function automatic logic dig_fits(input dig_t dv, input radix_t rdx);
    dig_t lim;
    case (rdx)
      RDX_DEC: lim = 9'sd10;
      RDX_HEX: lim = 9'sd16;
      RDX_BIN: lim = 9'sd2;
      RDX_OCT: lim = 9'sd8;
      default: lim = 9'sd10;
    endcase
    return dv < lim;
  endfunction

  function automatic radix_t pfx_radix(input pfx_t k);
    case (k)
      PFX_HEX: return RDX_HEX;
      PFX_OCT: return RDX_OCT;
      PFX_BIN: return RDX_BIN;
      default: return RDX_DEC;
    endcase
  endfunction

endpackage

// File: hw/rtl/nlp_decode.sv
// Character decode: lowercase, digit value and letter flags.
module nlp_decode
  import nlp_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  output dchar_t            dch
);

  logic [CHAR_W-1:0] lc;

  always_comb begin
    lc = char_code;
    if (char_code inside {[CH_UA:CH_UZ]}) begin
      lc = char_code + CASE_OFS;
    end
    if (lc >= CH_LA) begin
      dch.dv = $signed({1'b0, lc}) - $signed({1'b0, CH_LA}) + 9'sd10;
    end else begin
      dch.dv = $signed({1'b0, lc}) - $signed({1'b0, CH_ZERO});
    end
    dch.is_x    = (lc == CH_X);
    dch.is_o    = (lc == CH_O);
    dch.is_b    = (lc == CH_B);
    dch.is_h    = (lc == CH_H);
    dch.is_zero = (lc == CH_ZERO);
  end

endmodule

// File: hw/rtl/nlp_core.sv
// Literal state, per-radix accumulators and result selection.
module nlp_core
  import nlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  logic      is_last,
  input  dchar_t    dch,
  output out_item_t res
);

  logic [1:0] pos_r, pos_nxt;
  logic       lead_zero_r, lead_zero_nxt;
  pfx_t       pfx_r, pfx_nxt;
  acc_t       dec_r, dec_nxt, hex_r, hex_nxt, bin_r, bin_nxt, oct_r, oct_nxt;
  logic [3:0] wok_r, wok_nxt;
  acc_t       pacc_r, pacc_nxt;
  logic       pok_r, pok_nxt;

  acc_t       sel_acc;
  logic       sel_ok;
  pfx_t       kind;
  radix_t     prdx;

  always_comb begin
    kind = PFX_NONE;
    if (pos_r == 2'd2) begin
      kind = (pfx_r == PFX_BIN && dch.is_h) ? PFX_NONE : pfx_r;
    end
    prdx = pfx_radix(kind);
    if (pos_r == 2'd1 && lead_zero_r && (dch.is_x || dch.is_o || dch.is_b)) begin
      sel_acc = '0;
      sel_ok  = 1'b1;
    end else if (kind != PFX_NONE) begin
      sel_acc = acc_push(pacc_r, prdx, dch.dv);
      sel_ok  = pok_r && dig_fits(dch.dv, prdx);
    end else if (dch.is_h) begin
      sel_acc = hex_r;
      sel_ok  = wok_r[RDX_HEX];
    end else if (dch.is_b) begin
      sel_acc = bin_r;
      sel_ok  = wok_r[RDX_BIN];
    end else if (dch.is_o) begin
      sel_acc = oct_r;
      sel_ok  = wok_r[RDX_OCT];
    end else begin
      sel_acc = acc_push(dec_r, RDX_DEC, dch.dv);
      sel_ok  = wok_r[RDX_DEC] && dig_fits(dch.dv, RDX_DEC);
    end
    res.ok    = sel_ok;
    res.value = sel_ok ? VALUE_W'($signed(sel_acc)) : '0;
  end

  always_comb begin
    pos_nxt       = pos_r;
    lead_zero_nxt = lead_zero_r;
    pfx_nxt       = pfx_r;
    dec_nxt       = dec_r;
    hex_nxt       = hex_r;
    bin_nxt       = bin_r;
    oct_nxt       = oct_r;
    wok_nxt       = wok_r;
    pacc_nxt      = pacc_r;
    pok_nxt       = pok_r;
    if (fire) begin
      if (is_last) begin
        pos_nxt       = 2'd0;
        lead_zero_nxt = 1'b0;
        pfx_nxt       = PFX_NONE;
        dec_nxt       = '0;
        hex_nxt       = '0;
        bin_nxt       = '0;
        oct_nxt       = '0;
        wok_nxt       = 4'hF;
        pacc_nxt      = '0;
        pok_nxt       = 1'b1;
      end else begin
        if (pos_r == 2'd0) begin
          lead_zero_nxt = dch.is_zero;
        end else if (pos_r == 2'd1) begin
          if (lead_zero_r) begin
            if (dch.is_x) begin
              pfx_nxt = PFX_HEX;
            end else if (dch.is_o) begin
              pfx_nxt = PFX_OCT;
            end else if (dch.is_b) begin
              pfx_nxt = PFX_BIN;
            end
          end
        end else if (pfx_r != PFX_NONE) begin
          if (!dig_fits(dch.dv, pfx_radix(pfx_r))) begin
            pok_nxt = 1'b0;
          end
          pacc_nxt = acc_push(pacc_r, pfx_radix(pfx_r), dch.dv);
        end
        dec_nxt = acc_push(dec_r, RDX_DEC, dch.dv);
        hex_nxt = acc_push(hex_r, RDX_HEX, dch.dv);
        bin_nxt = acc_push(bin_r, RDX_BIN, dch.dv);
        oct_nxt = acc_push(oct_r, RDX_OCT, dch.dv);
        wok_nxt[RDX_DEC] = wok_r[RDX_DEC] && dig_fits(dch.dv, RDX_DEC);
        wok_nxt[RDX_HEX] = wok_r[RDX_HEX] && dig_fits(dch.dv, RDX_HEX);
        wok_nxt[RDX_BIN] = wok_r[RDX_BIN] && dig_fits(dch.dv, RDX_BIN);
        wok_nxt[RDX_OCT] = wok_r[RDX_OCT] && dig_fits(dch.dv, RDX_OCT);
        if (pos_r != 2'd2) begin
          pos_nxt = pos_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      lead_zero_r <= 1'b0;
      pfx_r       <= PFX_NONE;
      dec_r       <= '0;
      hex_r       <= '0;
      bin_r       <= '0;
      oct_r       <= '0;
      wok_r       <= 4'hF;
      pacc_r      <= '0;
      pok_r       <= 1'b1;
    end else begin
      pos_r       <= pos_nxt;
      lead_zero_r <= lead_zero_nxt;
      pfx_r       <= pfx_nxt;
      dec_r       <= dec_nxt;
      hex_r       <= hex_nxt;
      bin_r       <= bin_nxt;
      oct_r       <= oct_nxt;
      wok_r       <= wok_nxt;
      pacc_r      <= pacc_nxt;
      pok_r       <= pok_nxt;
    end
  end

endmodule

// File: hw/rtl/numeric_literal_parser.sv
// Top level of the streaming integer literal parser.
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall   in_item_t  (char_code, is_last)
//   out_     out  out_valid / out_stall out_item_t (value, ok)
// One character per cycle while no last character waits on a stalled result; a
// last character passes the input register, then its result the output register.
// Reset (rst_n low, synchronous) empties both registers and restarts the literal.
// A stalled result holds; characters that are not last keep flowing meanwhile.
module numeric_literal_parser
  import nlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      advance;
  dchar_t    dch;
  out_item_t res;

  assign advance  = s1_valid_r && (!s1_data_r.is_last || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  nlp_decode u_decode (
    .char_code (s1_data_r.char_code),
    .dch       (dch)
  );

  nlp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .is_last (s1_data_r.is_last),
    .dch     (dch),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_data_r.is_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_data_r.is_last) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
